@@ sv/resampling_sample_player_assert.svh @@
// Assertion macros used by the sample player checker.
`ifndef RESAMPLING_SAMPLE_PLAYER_ASSERT_SVH
`define RESAMPLING_SAMPLE_PLAYER_ASSERT_SVH

// Implication in the same cycle, ignored during reset.
`define RSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sample player assertion failed");

// Implication in the next cycle, ignored during reset.
`define RSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sample player assertion failed");

// Implication in the next cycle, checked in reset as well.
`define RSP_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sample player assertion failed");

`endif

@@ sv/rsp_pkg.sv @@
// Shared constants and types of the resampling sample player.
package rsp_pkg;

  localparam int DEF_MAX_SAMPLES  = 65536;
  localparam int DEF_MAX_CHANNELS = 2;
  localparam int DEF_FRAC_BITS    = 16;

  localparam int POS_W     = 40;
  localparam int RATE_W    = 24;
  localparam int IP_W      = POS_W + RATE_W - 16;
  localparam int MOD_STEPS = 4;
  localparam int MOD_STG   = IP_W / MOD_STEPS;
  localparam int CNT_MAX_W = 21;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;
  localparam int FIFO_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_RATE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHANS = 3'd4;

  localparam logic [15:0] GAIN_MAX = 16'd32768;

  typedef struct packed {
    logic [RATE_W-1:0]    rate;
    logic                 loop_en;
    logic [15:0]          gain;
    logic [CNT_MAX_W-1:0] count;
    logic [2:0]           nch_m1;
  } cfg_t;

endpackage

@@ sv/rsp_ram.sv @@
// Generic RAM: one write port, two registered read ports.
module rsp_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  output logic [W-1:0]  rdata0,
  output logic [W-1:0]  rdata1
);

  logic [W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem_r[raddr0];
      rdata1 <= mem_r[raddr1];
    end
  end

endmodule

@@ sv/rsp_fifo.sv @@
// Small register queue between the front and back parts.
module rsp_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

@@ sv/rsp_front.sv @@
// Front part: accept items, scale position, reduce index, classify.
module rsp_front import rsp_pkg::*; #(
  parameter int MAX_SAMPLES  = DEF_MAX_SAMPLES,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int FRAC_BITS    = DEF_FRAC_BITS,
  parameter int QW           = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_req_type,
  input  logic             in_chan,
  input  logic [15:0]      in_load_index,
  input  logic [15:0]      in_load_value,
  input  logic [POS_W-1:0] in_host_position,
  output logic             q_push,
  input  logic             q_full,
  output logic [QW-1:0]    q_data
);

  localparam int IDX_W  = $clog2(MAX_SAMPLES);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ADDR_W = CH_W + IDX_W;
  localparam int HALF   = POS_W / 2;
  localparam int PP_W   = HALF + RATE_W;

  typedef struct packed {
    logic        req;
    logic        chan;
    logic [15:0] lidx;
    logic [15:0] lval;
    logic [15:0] frac;
  } tag_t;

  typedef struct packed {
    logic                 render;
    logic                 wr;
    logic                 zero;
    logic                 last;
    logic [ADDR_W-1:0]    addr;
    logic [FRAC_BITS-1:0] fw;
    logic [15:0]          lval;
  } q_item_t;

  logic                adv;
  logic [CNT_W-1:0]    cnt;
  logic [CH_W-1:0]     nch_m1;

  logic                v1_r;
  tag_t                tag1_r;
  logic [PP_W-1:0]     pph_r, ppl_r;
  logic                v2_r;
  tag_t                tag2_r;
  logic [IP_W-1:0]     ip2_r;
  logic [2*PP_W:0]     prod;

  logic                mv_r   [MOD_STG];
  tag_t                mtag_r [MOD_STG];
  logic [IP_W-1:0]     mdvd_r [MOD_STG];
  logic [CNT_W-1:0]    mrem_r [MOD_STG];
  logic                mpast_r[MOD_STG];
  logic [IDX_W-1:0]    milo_r [MOD_STG];

  tag_t                ft;
  logic [IDX_W-1:0]    idx;
  logic [CH_W-1:0]     src_ch;
  logic [FRAC_BITS+15:0] fw_ext;
  q_item_t             qi;

  assign cnt    = CNT_W'(cfg.count);
  assign nch_m1 = CH_W'(cfg.nch_m1);
  assign adv    = !(mv_r[MOD_STG-1] && q_full);
  assign in_ready = adv;
  assign prod   = (2*PP_W+1)'({pph_r, HALF'(0)}) + (2*PP_W+1)'(ppl_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag1_r.req  <= in_req_type;
      tag1_r.chan <= in_chan;
      tag1_r.lidx <= in_load_index;
      tag1_r.lval <= in_load_value;
      tag1_r.frac <= '0;
      pph_r <= PP_W'(in_host_position[POS_W-1:HALF] * cfg.rate);
      ppl_r <= PP_W'(in_host_position[HALF-1:0] * cfg.rate);
      tag2_r      <= {tag1_r.req, tag1_r.chan, tag1_r.lidx, tag1_r.lval, prod[15:0]};
      ip2_r       <= prod[IP_W+15:16];
    end
  end

  function automatic logic [CNT_W+IP_W-1:0] mod_steps(
    input logic [CNT_W-1:0] rem_i,
    input logic [IP_W-1:0]  dvd_i,
    input logic [CNT_W-1:0] d
  );
    logic [CNT_W-1:0] rem;
    logic [IP_W-1:0]  dvd;
    logic [CNT_W:0]   t;
    rem = rem_i;
    dvd = dvd_i;
    for (int j = 0; j < MOD_STEPS; j++) begin
      t   = {rem, dvd[IP_W-1]};
      dvd = {dvd[IP_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        rem = CNT_W'(t - {1'b0, d});
      end else begin
        rem = t[CNT_W-1:0];
      end
    end
    return {rem, dvd};
  endfunction

  for (genvar k = 0; k < MOD_STG; k++) begin : g_mod
    logic                  v_in;
    tag_t                  tag_in;
    logic [IP_W-1:0]       dvd_in;
    logic [CNT_W-1:0]      rem_in;
    logic                  past_in;
    logic [IDX_W-1:0]      ilo_in;
    logic [CNT_W+IP_W-1:0] res;

    if (k == 0) begin : g_first
      assign v_in    = v2_r;
      assign tag_in  = tag2_r;
      assign dvd_in  = ip2_r;
      assign rem_in  = '0;
      assign past_in = (ip2_r >= IP_W'(cnt));
      assign ilo_in  = ip2_r[IDX_W-1:0];
    end else begin : g_rest
      assign v_in    = mv_r[k-1];
      assign tag_in  = mtag_r[k-1];
      assign dvd_in  = mdvd_r[k-1];
      assign rem_in  = mrem_r[k-1];
      assign past_in = mpast_r[k-1];
      assign ilo_in  = milo_r[k-1];
    end

    assign res = mod_steps(rem_in, dvd_in, cnt);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        mv_r[k] <= 1'b0;
      end else if (adv) begin
        mv_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        mtag_r[k]  <= tag_in;
        mdvd_r[k]  <= res[IP_W-1:0];
        mrem_r[k]  <= res[CNT_W+IP_W-1:IP_W];
        mpast_r[k] <= past_in;
        milo_r[k]  <= ilo_in;
      end
    end
  end

  always_comb begin
    ft     = mtag_r[MOD_STG-1];
    idx    = cfg.loop_en ? mrem_r[MOD_STG-1][IDX_W-1:0] : milo_r[MOD_STG-1];
    src_ch = (CH_W'(ft.chan) < nch_m1) ? CH_W'(ft.chan) : nch_m1;
    fw_ext = {ft.frac, FRAC_BITS'(0)};
    qi.render = ft.req;
    qi.wr     = !ft.req && (32'(ft.lidx) < MAX_SAMPLES) && (32'(ft.chan) < MAX_CHANNELS);
    qi.zero   = (cnt == '0) || (!cfg.loop_en && mpast_r[MOD_STG-1]);
    qi.last   = ((CNT_W'(idx) + CNT_W'(1)) == cnt);
    qi.addr   = ft.req ? {src_ch, idx} : {CH_W'(ft.chan), IDX_W'(ft.lidx)};
    qi.fw     = fw_ext[FRAC_BITS+15:16];
    qi.lval   = ft.lval;
  end

  assign q_push = mv_r[MOD_STG-1] && !q_full;
  assign q_data = QW'(qi);

endmodule

@@ sv/rsp_back.sv @@
// Back part: sample store, interpolation, gain, saturation, result register.
module rsp_back import rsp_pkg::*; #(
  parameter int MAX_SAMPLES  = DEF_MAX_SAMPLES,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int FRAC_BITS    = DEF_FRAC_BITS,
  parameter int QW           = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               q_empty,
  input  logic [QW-1:0]      q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample
);

  localparam int IDX_W  = $clog2(MAX_SAMPLES);
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ADDR_W = CH_W + IDX_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int MF_W   = FRAC_BITS + 18;
  localparam int VW     = FRAC_BITS + 19;
  localparam int AW     = VW + 17;
  localparam int RW     = AW - (FRAC_BITS + 14);
  localparam logic signed [AW-1:0] RND = AW'(1) << (FRAC_BITS + 13);
  localparam logic signed [RW-1:0] SMAX = RW'(32767);
  localparam logic signed [RW-1:0] SMIN = -RW'(32768);

  typedef struct packed {
    logic                 render;
    logic                 wr;
    logic                 zero;
    logic                 last;
    logic [ADDR_W-1:0]    addr;
    logic [FRAC_BITS-1:0] fw;
    logic [15:0]          lval;
  } q_item_t;

  q_item_t              qi;
  logic                 adv;
  logic [IDX_W-1:0]     qidx;
  logic [15:0]          rd0, rd1;

  logic                 b1v_r, b1zero_r, b1last_r;
  logic [FRAC_BITS-1:0] b1fw_r;
  logic                 b2v_r, b2zero_r;
  logic signed [15:0]   b2s0_r;
  logic signed [MF_W-1:0] b2mf_r;
  logic                 b3v_r, b3zero_r;
  logic signed [VW-1:0] b3v_val_r;
  logic                 b4v_r, b4zero_r;
  logic signed [AW-1:0] b4acc_r;
  logic                 out_valid_r;
  logic signed [15:0]   out_sample_r;

  logic signed [16:0]   diff;
  logic signed [MF_W-1:0] mf;
  logic signed [AW-1:0] rnd_sum;
  logic signed [RW-1:0] shr;
  logic signed [15:0]   sat;

  assign qi    = q_item_t'(q_data);
  assign adv   = !out_valid_r || out_ready;
  assign q_pop = adv && !q_empty;
  assign qidx  = qi.addr[IDX_W-1:0];

  rsp_ram #(
    .W     (16),
    .DEPTH (DEPTH),
    .AW    (ADDR_W)
  ) u_store (
    .clk    (clk),
    .we     (q_pop && qi.wr),
    .waddr  (qi.addr),
    .wdata  (qi.lval),
    .re     (adv),
    .raddr0 (qi.addr),
    .raddr1 ({qi.addr[ADDR_W-1:IDX_W], qidx + IDX_W'(1)}),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  always_comb begin
    diff    = 17'($signed(rd1)) - 17'($signed(rd0));
    mf      = MF_W'($signed({1'b0, b1fw_r}) * diff);
    rnd_sum = b4acc_r + RND;
    shr     = RW'(rnd_sum >>> (FRAC_BITS + 14));
    if (shr > SMAX) begin
      sat = 16'(SMAX);
    end else if (shr < SMIN) begin
      sat = 16'(SMIN);
    end else begin
      sat = 16'(shr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1v_r       <= 1'b0;
      b2v_r       <= 1'b0;
      b3v_r       <= 1'b0;
      b4v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      b1v_r       <= q_pop && qi.render;
      b2v_r       <= b1v_r;
      b3v_r       <= b2v_r;
      b4v_r       <= b3v_r;
      out_valid_r <= b4v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1zero_r  <= qi.zero;
      b1last_r  <= qi.last;
      b1fw_r    <= qi.fw;
      b2zero_r  <= b1zero_r;
      b2s0_r    <= $signed(rd0);
      b2mf_r    <= b1last_r ? '0 : mf;
      b3zero_r  <= b2zero_r;
      b3v_val_r <= (VW'(b2s0_r) <<< FRAC_BITS) + VW'(b2mf_r);
      b4zero_r  <= b3zero_r;
      b4acc_r   <= AW'(b3v_val_r * $signed({1'b0, cfg.gain}));
      out_sample_r <= b4zero_r ? '0 : sat;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

endmodule

@@ sv/resampling_sample_player.sv @@
// Input beat to result beat: 2 multiply, 12 modulo, 1 queue and 5 store and
// arithmetic stages, held by backpressure from the output or a full queue.
// Throughput: one item per cycle unless stalled; the position multiply and modulo
// are pipelined; the store reads both neighbors at once through two read ports.
// Reset clears all valid state and sets the configuration to its defaults; the
// sample store is not cleared and holds undefined data until loaded.
module resampling_sample_player import rsp_pkg::*; #(
  parameter int MAX_SAMPLES  = DEF_MAX_SAMPLES,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_req_type,
  input  logic                 in_chan,
  input  logic [15:0]          in_load_index,
  input  logic signed [15:0]   in_load_value,
  input  logic [POS_W-1:0]     in_host_position,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   out_sample,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int IDX_W  = $clog2(MAX_SAMPLES);
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int QW     = 4 + CH_W + IDX_W + FRAC_BITS + 16;

  cfg_t          cfg_r, cfg_nxt;
  logic          q_push, q_full, q_pop, q_empty;
  logic [QW-1:0] q_din, q_dout;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_RATE:  cfg_nxt.rate = cfg_data[RATE_W-1:0];
        REG_LOOP:  cfg_nxt.loop_en = cfg_data[0];
        REG_GAIN:  cfg_nxt.gain = (cfg_data[15:0] > GAIN_MAX) ? GAIN_MAX : cfg_data[15:0];
        REG_COUNT: cfg_nxt.count = (32'(cfg_data[16:0]) > MAX_SAMPLES) ?
                     CNT_MAX_W'(MAX_SAMPLES) : CNT_MAX_W'(cfg_data[16:0]);
        REG_CHANS: cfg_nxt.nch_m1 = (cfg_data[1:0] == 2'd0) ? 3'd0 :
                     (32'(cfg_data[1:0]) > MAX_CHANNELS) ? 3'(MAX_CHANNELS - 1) :
                     3'(cfg_data[1:0] - 2'd1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rate    <= RATE_W'(65536);
      cfg_r.loop_en <= 1'b0;
      cfg_r.gain    <= 16'd16384;
      cfg_r.count   <= '0;
      cfg_r.nch_m1  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rsp_front #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .MAX_CHANNELS (MAX_CHANNELS),
    .FRAC_BITS    (FRAC_BITS),
    .QW           (QW)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_chan          (in_chan),
    .in_load_index    (in_load_index),
    .in_load_value    (in_load_value),
    .in_host_position (in_host_position),
    .q_push           (q_push),
    .q_full           (q_full),
    .q_data           (q_din)
  );

  rsp_fifo #(
    .W     (QW),
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  rsp_back #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .MAX_CHANNELS (MAX_CHANNELS),
    .FRAC_BITS    (FRAC_BITS),
    .QW           (QW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_data     (q_dout),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample)
  );

endmodule

@@ sv/rsp_checker.sv @@
// Port-level checker for the sample player, bound to the top level.
`include "resampling_sample_player_assert.svh"

module rsp_checker import rsp_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic signed [15:0]   out_sample,
  input logic                 cfg_valid,
  input logic                 cfg_ready
);

  `RSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_sample))
  `RSP_ASSERT_NEXT_ALWAYS(a_rst_clear, !rst_n, !out_valid)
  `RSP_ASSERT_NOW(a_cfg_open, cfg_valid || in_valid, cfg_ready)

endmodule

bind resampling_sample_player rsp_checker u_rsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_sample (out_sample),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

@@ sim/resampling_sample_player_tb.sv @@
// Testbench for the resampling sample player: directed and random beats against a predictor.
module resampling_sample_player_tb import rsp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_req_type = 1'b0;
  logic                 in_chan = 1'b0;
  logic [15:0]          in_load_index = '0;
  logic signed [15:0]   in_load_value = '0;
  logic [POS_W-1:0]     in_host_position = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [15:0]   out_sample;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  resampling_sample_player u_top (.*);

  always #2 clk = ~clk;

  logic [23:0]        rate_q = 24'd65536;
  logic               loop_q = 1'b0;
  logic [16:0]        gain_q = 17'd16384;
  logic [16:0]        count_q = '0;
  logic [1:0]         chans_q = 2'd1;
  logic signed [15:0] pcm_store [2][65536];
  bit                 pcm_written [2][65536];

  logic signed [15:0] sample_queue [$];
  int errors = 0;
  int n_loads = 0;
  int n_renders = 0;
  int n_checked = 0;
  int n_cfg = 0;
  bit quiet = 1'b0;

  function automatic int unsigned eff_count();
    return (count_q > 17'd65536) ? 65536 : count_q;
  endfunction

  function automatic int src_chan(logic ch);
    int nch;
    nch = (chans_q == 2'd0) ? 1 : (chans_q > 2'd2 ? 2 : chans_q);
    return (ch < nch - 1) ? ch : nch - 1;
  endfunction

  function automatic longint unsigned src_index(logic [39:0] pos);
    longint unsigned prod;
    longint unsigned ip;
    prod = {24'd0, pos} * {40'd0, rate_q};
    ip = prod >> 16;
    if (loop_q && eff_count() != 0) ip = ip % eff_count();
    return ip;
  endfunction

  function automatic logic signed [15:0] predict_sample(logic ch, logic [39:0] pos);
    longint unsigned prod;
    longint unsigned ip;
    longint fr, s0, s1, v, acc;
    int sc;
    int unsigned cnt;
    cnt = eff_count();
    if (cnt == 0) return 16'sd0;
    sc = src_chan(ch);
    prod = {24'd0, pos} * {40'd0, rate_q};
    fr = longint'(prod & 64'hFFFF);
    ip = src_index(pos);
    if (ip >= cnt) return 16'sd0;
    s0 = pcm_store[sc][ip];
    if (ip == cnt - 1) begin
      v = s0 * 65536;
    end else begin
      s1 = pcm_store[sc][ip + 1];
      v = s0 * 65536 + fr * (s1 - s0);
    end
    acc = (v * longint'(gain_q) + (longint'(1) << 29)) >>> 30;
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    return acc[15:0];
  endfunction

  always @(posedge clk) begin
    if (quiet) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 99) >= 8);
  end

  always @(posedge clk) begin
    logic signed [15:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (sample_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected out_sample: expected none, actual %0d", $time, out_sample);
      end else begin
        want = sample_queue.pop_front();
        n_checked++;
        if (out_sample !== want) begin
          errors++;
          $display("%0t: out_sample mismatch: expected %0d, actual %0d", $time, want,
                   out_sample);
        end
      end
    end
  end

  task automatic send_beat(logic rt, logic ch, logic [15:0] idx, logic [15:0] val,
                           logic [39:0] pos);
    int gap;
    if (!quiet && $urandom_range(0, 99) < 8) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rt;
    in_chan <= ch;
    in_load_index <= idx;
    in_load_value <= val;
    in_host_position <= pos;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic load_sample(logic ch, logic [15:0] idx, logic [15:0] val);
    send_beat(1'b0, ch, idx, val, 40'({$urandom, $urandom}));
    pcm_store[ch][idx] = val;
    pcm_written[ch][idx] = 1'b1;
    n_loads++;
  endtask

  task automatic render_at(logic ch, logic [39:0] pos);
    longint unsigned ip;
    int sc;
    int unsigned cnt;
    cnt = eff_count();
    sc = src_chan(ch);
    ip = src_index(pos);
    if (cnt != 0 && ip < cnt) begin
      if (!pcm_written[sc][ip]) load_sample(sc[0], ip[15:0], 16'($urandom));
      if (ip != cnt - 1 && !pcm_written[sc][ip + 1])
        load_sample(sc[0], ip[15:0] + 16'd1, 16'($urandom));
    end
    send_beat(1'b1, ch, 16'($urandom), 16'($urandom), pos);
    sample_queue.push_back(predict_sample(ch, pos));
    n_renders++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sample_queue.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    n_cfg++;
    case (idx)
      REG_RATE:  rate_q = d;
      REG_LOOP:  loop_q = d[0];
      REG_GAIN:  gain_q = (d[15:0] > GAIN_MAX) ? 17'(GAIN_MAX) : 17'(d[15:0]);
      REG_COUNT: count_q = d[16:0];
      REG_CHANS: chans_q = d[1:0];
      default: ;
    endcase
  endtask

  task automatic test_empty_store();
    render_at(1'b0, 40'd0);
    render_at(1'b1, 40'hFF_FFFF_FFFF);
    drain();
  endtask

  task automatic test_end_and_gain();
    write_reg(REG_COUNT, 24'd4);
    load_sample(1'b0, 16'd0, 16'h7FFF);
    load_sample(1'b0, 16'd1, 16'h8000);
    load_sample(1'b0, 16'd2, 16'h1234);
    load_sample(1'b0, 16'd3, 16'hFFFF);
    render_at(1'b0, 40'd3);
    render_at(1'b0, 40'd4);
    drain();
    write_reg(REG_RATE, 24'd32768);
    render_at(1'b0, 40'd1);
    render_at(1'b0, 40'd3);
    drain();
    write_reg(REG_GAIN, 24'd65535);
    render_at(1'b0, 40'd0);
    render_at(1'b0, 40'd2);
    render_at(1'b0, 40'd3);
    drain();
    write_reg(REG_GAIN, 24'd0);
    render_at(1'b0, 40'd1);
    drain();
    write_reg(REG_GAIN, 24'd16384);
    write_reg(3'd5, 24'hFFFFFF);
    write_reg(3'd7, 24'h000000);
    render_at(1'b0, 40'd5);
    drain();
  endtask

  task automatic test_loop_and_channels();
    write_reg(REG_LOOP, 24'd1);
    write_reg(REG_RATE, 24'hFFFFFF);
    write_reg(REG_CHANS, 24'd2);
    render_at(1'b1, 40'hFF_FFFF_FFFF);
    render_at(1'b0, 40'd7);
    drain();
    write_reg(REG_CHANS, 24'd0);
    render_at(1'b1, 40'd9);
    drain();
    write_reg(REG_CHANS, 24'd3);
    render_at(1'b1, 40'd11);
    drain();
    write_reg(REG_COUNT, 24'h01FFFF);
    write_reg(REG_RATE, 24'd65536);
    load_sample(1'b1, 16'hFFFF, 16'h4000);
    render_at(1'b1, 40'd65535);
    render_at(1'b1, 40'd65534);
    drain();
    write_reg(REG_LOOP, 24'd0);
    render_at(1'b1, 40'd65536);
    drain();
  endtask

  task automatic test_random();
    int unsigned cnt, lim;
    longint unsigned span;
    logic [39:0] pos;
    for (int ph = 0; ph < 12; ph++) begin
      quiet = (ph == 5);
      case ($urandom_range(0, 9))
        0: cnt = 0;
        1: cnt = 65536;
        2: cnt = 1;
        default: cnt = $urandom_range(2, 64);
      endcase
      write_reg(REG_COUNT, 24'(cnt));
      case ($urandom_range(0, 5))
        0: write_reg(REG_RATE, 24'd1);
        1: write_reg(REG_RATE, 24'hFFFFFF);
        default: write_reg(REG_RATE, 24'($urandom_range(4096, 262144)));
      endcase
      write_reg(REG_LOOP, 24'($urandom_range(0, 1)));
      write_reg(REG_GAIN, ($urandom_range(0, 3) == 0) ? 24'($urandom) :
                          24'($urandom_range(0, 32768)));
      write_reg(REG_CHANS, 24'($urandom_range(0, 3)));
      lim = (cnt == 0) ? 1 : cnt;
      for (int k = 0; k < 100; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          load_sample(1'($urandom), (cnt > 1 && $urandom_range(0, 1)) ?
                      16'($urandom_range(0, lim - 1)) : 16'($urandom), 16'($urandom));
        end else begin
          if (loop_q || $urandom_range(0, 5) == 0) begin
            pos = 40'({$urandom, $urandom});
          end else begin
            span = ((longint'(lim) + 1) << 16) / rate_q;
            pos = 40'($urandom_range(0, 32'((span > 64'hFFFFFFFE) ? 64'hFFFFFFFE : span)));
          end
          render_at(1'($urandom), pos);
        end
      end
      drain();
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_empty_store();
    test_end_and_gain();
    test_loop_and_channels();
    test_random();
    drain();
    $display("Covered %0d loads, %0d renders (%0d results checked), %0d register writes.",
             n_loads, n_renders, n_checked, n_cfg);
    $display("Settings spanned empty, short and full stores, loop on and off, gain extremes.");
    if (errors == 0 && sample_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout with %0d results outstanding", sample_queue.size());
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+sv
sv/rsp_pkg.sv
sv/rsp_ram.sv
sv/rsp_fifo.sv
sv/rsp_front.sv
sv/rsp_back.sv
sv/resampling_sample_player.sv
sv/rsp_checker.sv
sim/resampling_sample_player_tb.sv
